>>> rtl/core/nts_pkg.sv
// shared types, constants and digit tables for the nixie time serializer
package nts_pkg;

  localparam int unsigned FrameBits = 32;
  localparam int unsigned CntW      = $clog2(FrameBits);
  localparam int unsigned WordBits  = 16;

  localparam logic [5:0] MinuteLimit = 6'd60;
  localparam logic [4:0] HourLimit   = 5'd24;

  // cathode bit position for each digit value
  localparam logic [3:0] UnitsPos    [10] = '{4'd8, 4'd9, 4'd0, 4'd1, 4'd2,
                                              4'd3, 4'd4, 4'd5, 4'd6, 4'd7};
  localparam logic [3:0] MinTensPos  [6]  = '{4'd14, 4'd15, 4'd10, 4'd11, 4'd12, 4'd13};
  localparam logic [3:0] HourTensPos [3]  = '{4'd12, 4'd10, 4'd11};

  typedef enum logic {
    OP_SHOW  = 1'b0,
    OP_CLEAR = 1'b1
  } nts_op_e;

  typedef struct packed {
    nts_op_e    operation;
    logic [4:0] hours;
    logic [5:0] minutes;
  } nts_item_t;

  typedef struct packed {
    nts_op_e                operation;
    logic [FrameBits-1:0]   frame;
  } nts_frame_t;

endpackage

>>> rtl/core/nts_if.sv
// valid/ready channel interfaces for commands and serial bits
interface nts_cmd_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [4:0] hours;
  logic [5:0] minutes;

  modport source (output valid, output operation, output hours, output minutes,
                  input ready);
  modport sink   (input valid, input operation, input hours, input minutes,
                  output ready);
endinterface

interface nts_bit_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic clear_pulse;
  logic last;

  modport source (output valid, output serial_bit, output clear_pulse, output last,
                  input ready);
  modport sink   (input valid, input serial_bit, input clear_pulse, input last,
                  output ready);
endinterface

>>> rtl/core/nts_encode.sv
// digit split and cathode mapping into the 32-bit shift frame
module nts_encode (
  input  nts_pkg::nts_item_t  item_i,
  output nts_pkg::nts_frame_t frame_o
);
  import nts_pkg::*;

  logic [2:0]          m_tens;
  logic [1:0]          h_tens;
  logic [5:0]          m_units_full;
  logic [4:0]          h_units_full;
  logic [3:0]          m_units;
  logic [3:0]          h_units;
  logic [WordBits-1:0] min_word;
  logic [WordBits-1:0] hour_word;

  always_comb begin
    if (item_i.minutes >= 6'd50)      m_tens = 3'd5;
    else if (item_i.minutes >= 6'd40) m_tens = 3'd4;
    else if (item_i.minutes >= 6'd30) m_tens = 3'd3;
    else if (item_i.minutes >= 6'd20) m_tens = 3'd2;
    else if (item_i.minutes >= 6'd10) m_tens = 3'd1;
    else                              m_tens = 3'd0;

    if (item_i.hours >= 5'd20)      h_tens = 2'd2;
    else if (item_i.hours >= 5'd10) h_tens = 2'd1;
    else                            h_tens = 2'd0;

    m_units_full = item_i.minutes - 6'(m_tens) * 6'd10;
    h_units_full = item_i.hours - 5'(h_tens) * 5'd10;
    // clamp keeps table indexes in range when the word is blanked anyway
    m_units = (m_units_full > 6'd9) ? 4'd0 : m_units_full[3:0];
    h_units = (h_units_full > 5'd9) ? 4'd0 : h_units_full[3:0];

    if (item_i.minutes >= MinuteLimit) begin
      min_word = '0;
    end else begin
      min_word = (WordBits'(1) << UnitsPos[m_units]) |
                 (WordBits'(1) << MinTensPos[m_tens]);
    end

    if (item_i.hours >= HourLimit) begin
      hour_word = '0;
    end else begin
      hour_word = (WordBits'(1) << UnitsPos[h_units]) |
                  (WordBits'(1) << HourTensPos[h_tens]);
    end

    frame_o.operation = item_i.operation;
    // first byte out sits on top, msb first within each byte
    frame_o.frame     = {min_word[7:0], min_word[15:8], hour_word[7:0], hour_word[15:8]};
  end

endmodule

>>> rtl/core/nts_shifter.sv
// output shift register that emits one serial bit transaction per cycle while busy and the receiver is ready
module nts_shifter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_valid_i,
  output logic                load_ready_o,
  input  nts_pkg::nts_frame_t frame_i,
  nts_bit_if.source           bit_o
);
  import nts_pkg::*;

  logic                 busy_q, busy_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  nts_op_e              op_q, op_d;
  logic [FrameBits-1:0] frame_q, frame_d;
  logic                 out_fire;
  logic                 final_bit;
  logic                 load;

  assign final_bit    = (op_q == OP_CLEAR) || (cnt_q == CntW'(FrameBits - 1));
  assign out_fire     = busy_q && bit_o.ready;
  assign load_ready_o = !busy_q || (out_fire && final_bit);
  assign load         = load_valid_i && load_ready_o;

  assign bit_o.valid       = busy_q;
  assign bit_o.serial_bit  = (op_q == OP_CLEAR) ? 1'b0 : frame_q[FrameBits-1];
  assign bit_o.clear_pulse = (op_q == OP_CLEAR);
  assign bit_o.last        = final_bit;

  always_comb begin
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    op_d    = op_q;
    frame_d = frame_q;
    if (load) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      op_d    = frame_i.operation;
      frame_d = frame_i.frame;
    end else if (out_fire) begin
      if (final_bit) begin
        busy_d = 1'b0;
      end else begin
        cnt_d   = cnt_q + 1'b1;
        frame_d = {frame_q[FrameBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OP_SHOW;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

endmodule

>>> rtl/core/nixie_time_serializer.sv
// top level: command register, frame encoder and serial output shifter
// an accepted command is registered, then loaded into the shifter, which sends its bits
// throughput: a show command holds the shifter for 32 bit transactions, a clear for one;
//   the command register takes the next command while the shifter is still busy
// the 32-bit shift register and its 5-bit bit counter set the per-command rate
// reset: asynchronous active low, clears the valid flags, bit counter and operation only
module nixie_time_serializer (
  input  logic      clk_i,
  input  logic      rst_ni,
  nts_cmd_if.sink   cmd_i,
  nts_bit_if.source bits_o
);
  import nts_pkg::*;

  // command register, decoupled from the shifter so a new transaction can land early
  logic       cmd_vld_q, cmd_vld_d;
  nts_item_t  cmd_q, cmd_d;
  nts_item_t  cmd_in;
  nts_frame_t frame;
  logic       load_ready;
  logic       cmd_fire;

  assign cmd_in.operation = nts_op_e'(cmd_i.operation);
  assign cmd_in.hours     = cmd_i.hours;
  assign cmd_in.minutes   = cmd_i.minutes;

  // accept when the register is empty or is handing its command to the shifter now
  assign cmd_i.ready = !cmd_vld_q || load_ready;
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;

  always_comb begin
    cmd_vld_d = cmd_vld_q;
    cmd_d     = cmd_q;
    if (cmd_fire) begin
      cmd_vld_d = 1'b1;
      cmd_d     = cmd_in;
    end else if (load_ready) begin
      cmd_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
    end else begin
      cmd_vld_q <= cmd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  // tens/units split and cathode lookup, straight from the command register
  nts_encode u_encode (
    .item_i  (cmd_q),
    .frame_o (frame)
  );

  // serial output stage, loads a new frame when idle or on the cycle the last bit leaves
  nts_shifter u_shifter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (cmd_vld_q),
    .load_ready_o (load_ready),
    .frame_i      (frame),
    .bit_o        (bits_o)
  );

endmodule

>>> test/testbench.sv
// self-checking testbench for the nixie time serializer: commands in, serial tube bits out
module testbench;
  import nts_pkg::*;

  // one serial bit transaction as the tube shift chain should see it
  typedef struct packed {
    logic serial_bit;
    logic clear_pulse;
    logic last;
  } tube_bit_t;

  // cathode position of each digit, per tube
  localparam int UNIT_CATHODE     [10] = '{8, 9, 0, 1, 2, 3, 4, 5, 6, 7};
  localparam int MIN_TENS_CATHODE [6]  = '{14, 15, 10, 11, 12, 13};
  localparam int HOUR_TENS_CATHODE[3]  = '{12, 10, 11};
  localparam int MINUTES_SHOWN = 60;
  localparam int HOURS_SHOWN   = 24;

  localparam int IDLE_PCT      = 18;
  localparam int RANDOM_CMDS   = 110;
  localparam int HOLD_AT_BITS  = 100;
  localparam int HOLD_CYCLES   = 400;
  localparam int CALM_FROM     = 1500;
  localparam int CALM_TO       = 3000;
  localparam int DRAIN_CYCLES  = 16;

  logic clk;
  logic rst_n;

  nts_cmd_if cmd_if ();
  nts_bit_if bit_if ();

  nixie_time_serializer u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd_if),
    .bits_o (bit_if)
  );

  nts_item_t pending_cmds[$];
  tube_bit_t tube_bits_q[$];
  int        err_cnt;
  int        bit_cnt;
  int        cyc;
  int        hold_left;
  bit        hold_done;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cyc, what);
    err_cnt++;
  endtask

  function automatic logic [15:0] minute_cathodes(input logic [5:0] m);
    if (m >= MINUTES_SHOWN) return '0;
    return (16'd1 << UNIT_CATHODE[m % 10]) | (16'd1 << MIN_TENS_CATHODE[m / 10]);
  endfunction

  function automatic logic [15:0] hour_cathodes(input logic [4:0] h);
    if (h >= HOURS_SHOWN) return '0;
    return (16'd1 << UNIT_CATHODE[h % 10]) | (16'd1 << HOUR_TENS_CATHODE[h / 10]);
  endfunction

  // queue up the tube bits that one accepted command must produce
  task automatic push_tube_frame(input nts_item_t c);
    logic [15:0] mw;
    logic [15:0] hw;
    logic [31:0] stream;
    tube_bit_t   tb;
    if (c.operation == OP_CLEAR) begin
      tb.serial_bit  = 1'b0;
      tb.clear_pulse = 1'b1;
      tb.last        = 1'b1;
      tube_bits_q.push_back(tb);
    end else begin
      mw = minute_cathodes(c.minutes);
      hw = hour_cathodes(c.hours);
      // minutes low, minutes high, hours low, hours high; msb first in each byte
      stream = {mw[7:0], mw[15:8], hw[7:0], hw[15:8]};
      for (int k = 0; k < 32; k++) begin
        tb.serial_bit  = stream[31 - k];
        tb.clear_pulse = 1'b0;
        tb.last        = (k == 31);
        tube_bits_q.push_back(tb);
      end
    end
  endtask

  task automatic add_cmd(input nts_op_e op, input int h, input int m);
    nts_item_t c;
    c.operation = op;
    c.hours     = h[4:0];
    c.minutes   = m[5:0];
    pending_cmds.push_back(c);
  endtask

  function automatic bit idle_now();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cyc <= cyc + 1;

  // command driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      cmd_if.valid     <= 1'b0;
      cmd_if.operation <= OP_SHOW;
      cmd_if.hours     <= '0;
      cmd_if.minutes   <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        push_tube_frame(pending_cmds.pop_front());
      end
      // an offered command stays put until it is taken
      if (!(cmd_if.valid && !cmd_if.ready)) begin
        if (pending_cmds.size() != 0 && !idle_now()) begin
          cmd_if.valid     <= 1'b1;
          cmd_if.operation <= pending_cmds[0].operation;
          cmd_if.hours     <= pending_cmds[0].hours;
          cmd_if.minutes   <= pending_cmds[0].minutes;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off so the command side backs up
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && bit_cnt >= HOLD_AT_BITS) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // bit monitor and receiver back-pressure
  always @(posedge clk or negedge rst_n) begin
    tube_bit_t exp_bit;
    if (!rst_n) begin
      bit_if.ready <= 1'b0;
      bit_cnt      <= 0;
    end else begin
      if (bit_if.valid && bit_if.ready) begin
        bit_cnt <= bit_cnt + 1;
        if (tube_bits_q.size() == 0) begin
          report_mismatch("bit transaction with nothing expected");
        end else begin
          exp_bit = tube_bits_q.pop_front();
          if (bit_if.serial_bit !== exp_bit.serial_bit)
            report_mismatch($sformatf("serial_bit %b, expected %b",
                                      bit_if.serial_bit, exp_bit.serial_bit));
          if (bit_if.clear_pulse !== exp_bit.clear_pulse)
            report_mismatch($sformatf("clear_pulse %b, expected %b",
                                      bit_if.clear_pulse, exp_bit.clear_pulse));
          if (bit_if.last !== exp_bit.last)
            report_mismatch($sformatf("last %b, expected %b",
                                      bit_if.last, exp_bit.last));
        end
      end
      if (hold_left > 0 || (!hold_done && bit_cnt >= HOLD_AT_BITS)) begin
        bit_if.ready <= 1'b0;
      end else begin
        bit_if.ready <= !idle_now();
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int r;
    err_cnt = 0;
    rst_n   = 1'b0;

    // directed: field extremes, both tens tables, blanking and clears
    add_cmd(OP_SHOW, 0, 0);
    add_cmd(OP_SHOW, 23, 59);
    add_cmd(OP_SHOW, 12, 34);
    add_cmd(OP_SHOW, 9, 9);
    add_cmd(OP_SHOW, 19, 45);
    add_cmd(OP_SHOW, 20, 50);
    add_cmd(OP_SHOW, 10, 18);
    add_cmd(OP_SHOW, 5, 27);
    add_cmd(OP_SHOW, 1, 36);
    add_cmd(OP_SHOW, 24, 0);
    add_cmd(OP_SHOW, 31, 63);
    add_cmd(OP_SHOW, 7, 60);
    add_cmd(OP_SHOW, 0, 63);
    add_cmd(OP_SHOW, 31, 0);
    add_cmd(OP_CLEAR, 31, 63);
    add_cmd(OP_CLEAR, 0, 0);
    add_cmd(OP_CLEAR, 12, 34);
    add_cmd(OP_SHOW, 8, 41);
    add_cmd(OP_CLEAR, 24, 60);
    add_cmd(OP_SHOW, 16, 52);

    // random: mostly valid times, some blanking values and clears
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      r = $urandom_range(99);
      if (r < 15)
        add_cmd(OP_CLEAR, $urandom_range(31), $urandom_range(63));
      else if (r < 30)
        add_cmd(OP_SHOW, $urandom_range(31), $urandom_range(63));
      else
        add_cmd(OP_SHOW, $urandom_range(23), $urandom_range(59));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_cmds.size() != 0 || tube_bits_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tube_bits_q.size() != 0)
      report_mismatch($sformatf("%0d bit transactions never arrived", tube_bits_q.size()));

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
